// ===== rtl/core/stu_pkg.sv =====
// Shared types, constants and character helpers for the source tokenizer.
// No dependencies.
`default_nettype none

package stu_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [5:0] K_NEWLINE  = 6'd44;
  localparam logic [5:0] K_STRING   = 6'd45;
  localparam logic [5:0] K_INT      = 6'd46;
  localparam logic [5:0] K_FLOAT    = 6'd47;
  localparam logic [5:0] K_IDENT    = 6'd48;
  localparam logic [5:0] K_KEYWORD0 = 6'd49;
  localparam logic [5:0] K_ERROR    = 6'd57;
  localparam logic [5:0] K_END      = 6'd58;
  localparam logic [5:0] K_PIPE_GT  = 6'd21;
  localparam logic [5:0] K_FAT_ARR  = 6'd26;
  localparam logic [5:0] K_ARROW    = 6'd29;
  localparam logic [5:0] K_SHL      = 6'd32;
  localparam logic [5:0] K_SHR      = 6'd36;
  localparam logic [5:0] K_POW      = 6'd40;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_OP1,
    MODE_OP2,
    MODE_STR,
    MODE_STR_ESC,
    MODE_COMMENT,
    MODE_NUMBER,
    MODE_IDENT
  } mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [23:0] stop;
    logic [23:0] line;
    logic        last;
  } tok_t;

  // keyword spellings, zero padded to eight characters
  localparam logic [7:0] KW_TEXT [8][8] = '{
    '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "o", "d", "u", "l", "e", 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "a", "t", "c", "h", 8'h00, 8'h00, 8'h00},
    '{"u", "n", "l", "e", "s", "s", 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd2, 3'd6, 3'd6, 3'd2, 3'd5, 3'd6, 3'd4};

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == "_") || (c == "!") || (c == "?");
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "+":     k = 6'd0;
      "/":     k = 6'd2;
      "^":     k = 6'd4;
      "&":     k = 6'd6;
      "!":     k = 6'd8;
      "|":     k = 6'd22;
      "%":     k = 6'd24;
      "=":     k = 6'd27;
      "-":     k = 6'd30;
      "<":     k = 6'd34;
      ">":     k = 6'd38;
      "*":     k = 6'd42;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] double_kind(logic [7:0] c);
    logic [5:0] k;
    if (c == "<") k = K_SHL;
    else if (c == ">") k = K_SHR;
    else k = K_POW;
    return k;
  endfunction

  // one-byte tokens that never wait for lookahead; K_ERROR if none
  function automatic logic [5:0] punct_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "~":     k = 6'd10;
      "(":     k = 6'd11;
      ")":     k = 6'd12;
      "[":     k = 6'd13;
      "]":     k = 6'd14;
      "{":     k = 6'd15;
      "}":     k = 6'd16;
      ".":     k = 6'd17;
      ":":     k = 6'd18;
      ";":     k = 6'd19;
      ",":     k = 6'd20;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] kw_step(logic [7:0] cand, logic [2:0] len, logic [7:0] c);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = cand[k] && (len < KW_LEN[k]) && (KW_TEXT[k][len] == c);
    end
    return r;
  endfunction

  function automatic logic [5:0] ident_kind(logic [7:0] cand, logic [2:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i] && (KW_LEN[i] == len)) k = K_KEYWORD0 + 6'(i);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stu_scan.sv =====
// Per-byte scanner: scan state registers and the next-state / token logic.
// Depends on stu_pkg.
`default_nettype none

module stu_scan #(
  parameter int POS_BITS = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    source_byte_i,
  input  wire logic          end_of_input_i,
  output stu_pkg::tok_t      tok_a_o,
  output logic               tok_a_vld_o,
  output stu_pkg::tok_t      tok_b_o,
  output logic               tok_b_vld_o
);

  localparam logic [POS_BITS-1:0] ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

  stu_pkg::mode_e      mode_q, mode_d;
  logic [7:0]          pend_q, pend_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [POS_BITS-1:0] off_q, off_d;
  logic [POS_BITS-1:0] line_q, line_d;
  logic                single_q, single_d;
  logic                dot_q, dot_d;
  logic [7:0]          cand_q, cand_d;
  logic [2:0]          len_q, len_d;

  logic                a_v, b_v, disp;
  logic [5:0]          a_kind, b_kind;
  logic [POS_BITS-1:0] a_e, b_s, b_e, b_line, pos_e;
  logic [7:0]          c;

  function automatic logic [23:0] to24(logic [POS_BITS-1:0] v);
    logic [POS_BITS+23:0] t;
    t = {24'd0, v};
    return t[23:0];
  endfunction

  always_comb begin
    c        = source_byte_i;
    pos_e    = off_q + ONE;
    mode_d   = mode_q;
    pend_d   = pend_q;
    start_d  = start_q;
    off_d    = off_q;
    line_d   = line_q;
    single_d = single_q;
    dot_d    = dot_q;
    cand_d   = cand_q;
    len_d    = len_q;
    a_v      = 1'b0;
    a_kind   = stu_pkg::K_ERROR;
    a_e      = off_q;
    b_v      = 1'b0;
    b_kind   = stu_pkg::K_END;
    b_s      = off_q;
    b_e      = off_q;
    b_line   = line_q;
    disp     = 1'b0;

    if (end_of_input_i) begin
      // flush pending token, then END, then back to reset values
      unique case (mode_q)
        stu_pkg::MODE_OP1: begin
          a_v = 1'b1; a_kind = stu_pkg::single_kind(pend_q);
        end
        stu_pkg::MODE_OP2: begin
          a_v = 1'b1; a_kind = stu_pkg::double_kind(pend_q);
        end
        stu_pkg::MODE_STR, stu_pkg::MODE_STR_ESC: begin
          a_v = 1'b1; a_kind = stu_pkg::K_ERROR;
        end
        stu_pkg::MODE_NUMBER: begin
          a_v = 1'b1; a_kind = dot_q ? stu_pkg::K_FLOAT : stu_pkg::K_INT;
        end
        stu_pkg::MODE_IDENT: begin
          a_v = 1'b1; a_kind = stu_pkg::ident_kind(cand_q, len_q);
        end
        default: a_v = 1'b0;
      endcase
      b_v      = 1'b1;
      mode_d   = stu_pkg::MODE_IDLE;
      pend_d   = 8'd0;
      start_d  = '0;
      off_d    = '0;
      line_d   = ONE;
      single_d = 1'b0;
      dot_d    = 1'b0;
      cand_d   = 8'hFF;
      len_d    = 3'd0;
    end else begin
      off_d = pos_e;
      // every newline byte bumps the line count, in any mode, until it saturates at all ones
      if ((c == 8'h0A) && (line_q != '1)) line_d = line_q + ONE;
      unique case (mode_q)
        stu_pkg::MODE_OP1: begin
          if ((c == ">") && ((pend_q == "|") || (pend_q == "=") || (pend_q == "-"))) begin
            a_v    = 1'b1;
            a_e    = pos_e;
            a_kind = (pend_q == "|") ? stu_pkg::K_PIPE_GT :
                     ((pend_q == "=") ? stu_pkg::K_FAT_ARR : stu_pkg::K_ARROW);
            mode_d = stu_pkg::MODE_IDLE;
          end else if ((c == pend_q) && ((c == "<") || (c == ">") || (c == "*"))) begin
            mode_d = stu_pkg::MODE_OP2;
          end else if ((c == "%") && (pend_q == "%")) begin
            mode_d = stu_pkg::MODE_COMMENT;
          end else if (c == "=") begin
            a_v    = 1'b1;
            a_e    = pos_e;
            a_kind = stu_pkg::single_kind(pend_q) + 6'd1;
            mode_d = stu_pkg::MODE_IDLE;
          end else begin
            a_v    = 1'b1;
            a_kind = stu_pkg::single_kind(pend_q);
            disp   = 1'b1;
          end
        end
        stu_pkg::MODE_OP2: begin
          a_v = 1'b1;
          if (c == "=") begin
            a_e    = pos_e;
            a_kind = stu_pkg::double_kind(pend_q) + 6'd1;
            mode_d = stu_pkg::MODE_IDLE;
          end else begin
            a_kind = stu_pkg::double_kind(pend_q);
            disp   = 1'b1;
          end
        end
        stu_pkg::MODE_STR: begin
          if (c == (single_q ? 8'h27 : 8'h22)) begin
            a_v    = 1'b1;
            a_e    = pos_e;
            a_kind = stu_pkg::K_STRING;
            mode_d = stu_pkg::MODE_IDLE;
          end else if (c == 8'h5C) begin
            mode_d = stu_pkg::MODE_STR_ESC;
          end
        end
        stu_pkg::MODE_STR_ESC: mode_d = stu_pkg::MODE_STR;
        stu_pkg::MODE_COMMENT: begin
          if (c == 8'h0A) mode_d = stu_pkg::MODE_IDLE;
        end
        stu_pkg::MODE_NUMBER: begin
          if (stu_pkg::is_digit(c) || (c == ".")) begin
            if (c == ".") dot_d = 1'b1;
          end else begin
            a_v    = 1'b1;
            a_kind = dot_q ? stu_pkg::K_FLOAT : stu_pkg::K_INT;
            disp   = 1'b1;
          end
        end
        stu_pkg::MODE_IDENT: begin
          if (stu_pkg::is_letter(c) || stu_pkg::is_digit(c) || (c == ".")) begin
            cand_d = stu_pkg::kw_step(cand_q, len_q, c);
            len_d  = (len_q == 3'd7) ? len_q : len_q + 3'd1;
          end else begin
            a_v    = 1'b1;
            a_kind = stu_pkg::ident_kind(cand_q, len_q);
            disp   = 1'b1;
          end
        end
        default: disp = 1'b1;
      endcase

      if (disp) begin
        start_d = off_q;
        mode_d  = stu_pkg::MODE_IDLE;
        b_s     = off_q;
        b_e     = pos_e;
        b_line  = line_d;
        if (stu_pkg::punct_kind(c) != stu_pkg::K_ERROR) begin
          b_v    = 1'b1;
          b_kind = stu_pkg::punct_kind(c);
        end else if (c == 8'h0A) begin
          b_v    = 1'b1;
          b_kind = stu_pkg::K_NEWLINE;
        end else if ((c == " ") || (c == 8'h09) || (c == 8'h0D)) begin
          b_v = 1'b0;
        end else if ((c == 8'h22) || (c == 8'h27)) begin
          single_d = (c == 8'h27);
          mode_d   = stu_pkg::MODE_STR;
        end else if (stu_pkg::single_kind(c) != stu_pkg::K_ERROR) begin
          pend_d = c;
          mode_d = stu_pkg::MODE_OP1;
        end else if (stu_pkg::is_letter(c)) begin
          cand_d = stu_pkg::kw_step(8'hFF, 3'd0, c);
          len_d  = 3'd1;
          mode_d = stu_pkg::MODE_IDENT;
        end else if (stu_pkg::is_digit(c)) begin
          dot_d  = 1'b0;
          mode_d = stu_pkg::MODE_NUMBER;
        end else begin
          b_v    = 1'b1;
          b_kind = stu_pkg::K_ERROR;
        end
      end
    end
  end

  assign tok_a_vld_o   = accept_i && a_v;
  assign tok_b_vld_o   = accept_i && b_v;
  assign tok_a_o.kind  = a_kind;
  assign tok_a_o.start = to24(start_q);
  assign tok_a_o.stop  = to24(a_e);
  assign tok_a_o.line  = to24(line_q);
  assign tok_a_o.last  = !b_v;
  assign tok_b_o.kind  = b_kind;
  assign tok_b_o.start = to24(b_s);
  assign tok_b_o.stop  = to24(b_e);
  assign tok_b_o.line  = to24(b_line);
  assign tok_b_o.last  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= stu_pkg::MODE_IDLE;
      pend_q   <= 8'd0;
      start_q  <= '0;
      off_q    <= '0;
      line_q   <= ONE;
      single_q <= 1'b0;
      dot_q    <= 1'b0;
      cand_q   <= 8'hFF;
      len_q    <= 3'd0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      start_q  <= start_d;
      off_q    <= off_d;
      line_q   <= line_d;
      single_q <= single_d;
      dot_q    <= dot_d;
      cand_q   <= cand_d;
      len_q    <= len_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_input_i |=> (mode_q == stu_pkg::MODE_IDLE) && (off_q == '0) &&
                                   (line_q == ONE))
    else $error("end marker did not restore scan state");

  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !end_of_input_i |=> off_q == $past(off_q) + ONE)
    else $error("byte offset did not advance by one");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count reached zero");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_input_i |-> tok_b_vld_o && (tok_b_o.kind == stu_pkg::K_END))
    else $error("end marker produced no end token");

endmodule

`default_nettype wire

// ===== rtl/core/stu_outq.sv =====
// Four-entry token queue: up to two pushes and one pop per cycle.
// Depends on stu_pkg.
`default_nettype none

module stu_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire stu_pkg::tok_t tok_a_i,
  input  wire logic          tok_a_vld_i,
  input  wire stu_pkg::tok_t tok_b_i,
  input  wire logic          tok_b_vld_i,
  output logic               room_o,
  output stu_pkg::tok_t      tok_o,
  output logic               valid_o,
  input  wire logic          ready_i
);

  stu_pkg::tok_t                 mem_q [stu_pkg::QDEPTH];
  logic [stu_pkg::QPTR_W-1:0]    wr_q, rd_q, wr_b;
  logic [stu_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign room_o  = (cnt_q <= stu_pkg::QCNT_W'(stu_pkg::QDEPTH - 2));
  assign wr_b    = wr_q + stu_pkg::QPTR_W'(tok_a_vld_i);

  always_comb begin
    cnt_d = cnt_q + stu_pkg::QCNT_W'(tok_a_vld_i) + stu_pkg::QCNT_W'(tok_b_vld_i)
            - stu_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (tok_a_vld_i) mem_q[wr_q] <= tok_a_i;
    if (tok_b_vld_i) mem_q[wr_b] <= tok_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_b + stu_pkg::QPTR_W'(tok_b_vld_i);
      rd_q  <= rd_q + stu_pkg::QPTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_a_vld_i || tok_b_vld_i) |-> cnt_q <= stu_pkg::QCNT_W'(stu_pkg::QDEPTH - 2))
    else $error("push into a queue without room");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stu_pkg::QCNT_W'(stu_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_b_only_with_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_a_vld_i && tok_b_vld_i |-> !tok_a_i.last && tok_b_i.last)
    else $error("last flag out of order in a token pair");

endmodule

`default_nettype wire

// ===== rtl/core/source_tokenizer_unit.sv =====
// Top level of the streaming source tokenizer.
// Depends on stu_pkg, stu_scan and stu_outq.
//
// Usage:
//   Input channel: one source byte per word (source_byte_i), or an end marker
//   (end_of_input_i = 1, byte ignored), on in_valid_i / in_ready_o.
//   Output channel: one token per word (kind, start, end, line, last_of_run)
//   on out_valid_o / out_ready_i. A byte yields zero, one or two tokens;
//   last_of_run marks the final token caused by one input word.
// Output path: tokens caused by a byte are written into the token queue
//   when that byte is accepted (queue registered, no bypass).
// Throughput: one input word per cycle. in_ready_o is high while the
//   four-entry token queue has room for two tokens, so the rate drops only
//   when the receiver takes fewer tokens than the text produces.
// Reset: asynchronous, active low. Scan state goes idle, offset 0, line 1,
//   and the token queue empties. An end marker returns the scan state to the
//   same values, so the next byte starts a new text.
// Stall: when out_ready_i is low, tokens wait in the queue; once fewer than
//   two entries are free, in_ready_o drops and no byte is taken.
// POS_BITS sets the width of the internal offset and line counters; the
//   output fields carry their low 24 bits.
`default_nettype none

module source_tokenizer_unit #(
  parameter int POS_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  source_byte_i,
  input  wire logic        end_of_input_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       token_kind_o,
  output logic [23:0]      token_start_o,
  output logic [23:0]      token_end_o,
  output logic [23:0]      line_number_o,
  output logic             last_of_run_o
);

  stu_pkg::tok_t tok_a, tok_b, tok_out;
  logic          tok_a_vld, tok_b_vld, accept, room;

  // accept only when both tokens of a worst-case byte fit in the queue
  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  stu_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .source_byte_i  (source_byte_i),
    .end_of_input_i (end_of_input_i),
    .tok_a_o        (tok_a),
    .tok_a_vld_o    (tok_a_vld),
    .tok_b_o        (tok_b),
    .tok_b_vld_o    (tok_b_vld)
  );

  // token queue doubles as the output register
  stu_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_a_i     (tok_a),
    .tok_a_vld_i (tok_a_vld),
    .tok_b_i     (tok_b),
    .tok_b_vld_i (tok_b_vld),
    .room_o      (room),
    .tok_o       (tok_out),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i)
  );

  assign token_kind_o  = tok_out.kind;
  assign token_start_o = tok_out.start;
  assign token_end_o   = tok_out.stop;
  assign line_number_o = tok_out.line;
  assign last_of_run_o = tok_out.last;

  a_end_gives_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_input_i |=> out_valid_o)
    else $error("end marker left the output empty");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= stu_pkg::K_END)
    else $error("token kind out of range");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room |-> !tok_a_vld && !tok_b_vld)
    else $error("tokens produced while the queue is full");

endmodule

`default_nettype wire
